// ===== src/pms_pkg.sv =====
// Shared types and constants for the polygon midpoint subdivider.
// Used by pms_front, pms_queue, pms_back and the top level.
package pms_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int MAX_VERTS      = 4;
   localparam int AXES           = 3;
   localparam int VERT_IDX_BITS  = $clog2(MAX_VERTS);
   localparam int VERT_CNT_BITS  = $clog2(MAX_VERTS + 1);

   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_QUAD,
      KIND_TRI,
      KIND_BAD
   } face_kind_type;

   localparam logic [2:0] CC_QUAD = 3'd4;
   localparam logic [2:0] CC_TRI  = 3'd3;
   localparam logic [2:0] CC_BAD  = 3'd0;

   localparam logic [1:0] QUAD_LAST_CORNER = 2'd3;
   localparam logic [1:0] TRI_LAST_CORNER  = 2'd2;
   localparam logic [1:0] LAST_SUB_FACE    = 2'd3;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// ===== src/pms_front.sv =====
// Front end: collects the vertices of one face, keeps running coordinate sums
// and classifies the face when its last vertex arrives. Depends on pms_pkg.
module pms_front #(
   parameter int COORD_BITS = pms_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_vx,
   input  logic signed [COORD_BITS-1:0] req_vy,
   input  logic signed [COORD_BITS-1:0] req_vz,
   input  logic                         req_final_vertex,
   input  pms_pkg::queue_status_type    q_status,
   output logic                         push,
   output logic signed [COORD_BITS-1:0] push_vert [pms_pkg::MAX_VERTS][pms_pkg::AXES],
   output logic signed [COORD_BITS+1:0] push_sum [pms_pkg::AXES],
   output pms_pkg::face_kind_type       push_kind
);
   import pms_pkg::*;

   logic signed [COORD_BITS-1:0] vert_ff [MAX_VERTS][AXES];
   logic signed [COORD_BITS-1:0] vert_in [MAX_VERTS][AXES];
   logic signed [COORD_BITS+1:0] sum_ff [AXES];
   logic signed [COORD_BITS+1:0] sum_in [AXES];
   logic signed [COORD_BITS+1:0] store_sum [AXES];
   logic signed [COORD_BITS-1:0] coord_in [AXES];
   logic [VERT_CNT_BITS-1:0]     count_ff, count_in, store_count;
   logic                         overflow_ff, overflow_in, store_overflow;
   logic                         accept;
   logic                         room;

   always_comb begin
      coord_in[0] = req_vx;
      coord_in[1] = req_vy;
      coord_in[2] = req_vz;

      req_stall = q_status.full;
      accept    = req_valid && !q_status.full;
      room      = count_ff < VERT_CNT_BITS'(MAX_VERTS);

      vert_in        = vert_ff;
      store_sum      = sum_ff;
      store_count    = count_ff;
      store_overflow = overflow_ff;

      if (accept) begin
         if (room) begin
            for (int ax = 0; ax < AXES; ax++) begin
               vert_in[count_ff[VERT_IDX_BITS-1:0]][ax] = coord_in[ax];
               store_sum[ax] = sum_ff[ax] + (COORD_BITS+2)'(coord_in[ax]);
            end
            store_count = count_ff + VERT_CNT_BITS'(1);
         end else begin
            store_overflow = 1'b1;
         end
      end

      push      = accept && req_final_vertex;
      push_vert = vert_in;
      push_sum  = store_sum;

      if (!store_overflow && store_count == VERT_CNT_BITS'(4)) begin
         push_kind = KIND_QUAD;
      end else if (!store_overflow && store_count == VERT_CNT_BITS'(3)) begin
         push_kind = KIND_TRI;
      end else begin
         push_kind = KIND_BAD;
      end

      sum_in      = store_sum;
      count_in    = store_count;
      overflow_in = store_overflow;
      // close the face: start the next one from scratch
      if (push) begin
         for (int ax = 0; ax < AXES; ax++) begin
            sum_in[ax] = '0;
         end
         count_in    = '0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      vert_ff <= vert_in;
      if (reset) begin
         for (int ax = 0; ax < AXES; ax++) begin
            sum_ff[ax] <= '0;
         end
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

endmodule

// ===== src/pms_queue.sv =====
// Short queue of closed faces between the front end and the emitter.
// Depends on pms_pkg for depth, vertex count and face kind.
module pms_queue #(
   parameter int COORD_BITS = pms_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic signed [COORD_BITS-1:0] push_vert [pms_pkg::MAX_VERTS][pms_pkg::AXES],
   input  logic signed [COORD_BITS+1:0] push_sum [pms_pkg::AXES],
   input  pms_pkg::face_kind_type       push_kind,
   input  logic                         pop,
   output logic signed [COORD_BITS-1:0] head_vert [pms_pkg::MAX_VERTS][pms_pkg::AXES],
   output logic signed [COORD_BITS+1:0] head_sum [pms_pkg::AXES],
   output pms_pkg::face_kind_type       head_kind,
   output pms_pkg::queue_status_type    q_status
);
   import pms_pkg::*;

   logic signed [COORD_BITS-1:0] ent_vert_ff [QUEUE_DEPTH][MAX_VERTS][AXES];
   logic signed [COORD_BITS+1:0] ent_sum_ff [QUEUE_DEPTH][AXES];
   face_kind_type                ent_kind_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]    fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + QUEUE_CNT_BITS'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QUEUE_CNT_BITS'(1);
      end

      head_vert      = ent_vert_ff[rd_ptr_ff];
      head_sum       = ent_sum_ff[rd_ptr_ff];
      head_kind      = ent_kind_ff[rd_ptr_ff];
      q_status.empty = (fill_ff == '0);
      q_status.full  = (fill_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_vert_ff[wr_ptr_ff] <= push_vert;
         ent_sum_ff[wr_ptr_ff]  <= push_sum;
         ent_kind_ff[wr_ptr_ff] <= push_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== src/pms_back.sv =====
// Back end: walks the sub-faces of the face at the queue head and emits one
// vertex per unstalled cycle via an output register. Depends on pms_pkg.
module pms_back #(
   parameter int COORD_BITS = pms_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [COORD_BITS-1:0] head_vert [pms_pkg::MAX_VERTS][pms_pkg::AXES],
   input  logic signed [COORD_BITS+1:0] head_sum [pms_pkg::AXES],
   input  pms_pkg::face_kind_type       head_kind,
   input  pms_pkg::queue_status_type    q_status,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_ox,
   output logic signed [COORD_BITS-1:0] rsp_oy,
   output logic signed [COORD_BITS-1:0] rsp_oz,
   output logic [1:0]                   rsp_sub_face,
   output logic [1:0]                   rsp_corner,
   output logic [2:0]                   rsp_corner_count,
   output logic                         rsp_face_end,
   output logic                         rsp_run_end,
   output logic                         rsp_bad_face
);
   import pms_pkg::*;

   logic [1:0]                   sub_ff, sub_in, corner_ff, corner_in;
   logic                         valid_ff, valid_in;
   logic signed [COORD_BITS-1:0] o_ff [AXES];
   logic signed [COORD_BITS-1:0] o_in [AXES];
   logic [1:0]                   sub_out_ff, corner_out_ff;
   logic [2:0]                   cc_ff;
   logic                         face_end_ff, run_end_ff, bad_ff;

   logic                         advance;
   logic                         last_result, face_end;
   logic [1:0]                   last_corner;
   logic [2:0]                   cc;
   logic                         use_center;
   logic [VERT_IDX_BITS-1:0]     idx_a, idx_b;
   logic signed [COORD_BITS:0]   mid_sum [AXES];

   always_comb begin
      advance    = !q_status.empty && (!valid_ff || !rsp_stall);
      use_center = 1'b0;
      idx_a      = '0;
      idx_b      = '0;
      // a plain corner is the midpoint of a vertex with itself
      unique case (head_kind)
         KIND_QUAD: begin
            last_corner = QUAD_LAST_CORNER;
            cc          = CC_QUAD;
            unique case (corner_ff)
               2'd0: begin idx_a = sub_ff; idx_b = sub_ff; end
               2'd1: begin idx_a = sub_ff; idx_b = sub_ff + 2'd1; end
               2'd2: use_center = 1'b1;
               default: begin idx_a = sub_ff - 2'd1; idx_b = sub_ff; end
            endcase
         end
         KIND_TRI: begin
            last_corner = TRI_LAST_CORNER;
            cc          = CC_TRI;
            if (sub_ff == LAST_SUB_FACE) begin
               unique case (corner_ff)
                  2'd0:    begin idx_a = 2'd0; idx_b = 2'd1; end
                  2'd1:    begin idx_a = 2'd1; idx_b = 2'd2; end
                  default: begin idx_a = 2'd0; idx_b = 2'd2; end
               endcase
            end else begin
               unique case (corner_ff)
                  2'd0: begin idx_a = sub_ff; idx_b = sub_ff; end
                  2'd1: begin
                     idx_a = sub_ff;
                     idx_b = (sub_ff == 2'd2) ? 2'd0 : sub_ff + 2'd1;
                  end
                  default: begin
                     idx_a = (sub_ff == 2'd0) ? 2'd2 : sub_ff - 2'd1;
                     idx_b = sub_ff;
                  end
               endcase
            end
         end
         default: begin
            last_corner = 2'd0;
            cc          = CC_BAD;
         end
      endcase

      for (int ax = 0; ax < AXES; ax++) begin
         mid_sum[ax] = (COORD_BITS+1)'(head_vert[idx_a][ax])
                     + (COORD_BITS+1)'(head_vert[idx_b][ax]);
         if (head_kind == KIND_BAD) begin
            o_in[ax] = '0;
         end else if (use_center) begin
            o_in[ax] = head_sum[ax][COORD_BITS+1:2];
         end else begin
            o_in[ax] = mid_sum[ax][COORD_BITS:1];
         end
      end

      face_end    = (head_kind == KIND_BAD) || (corner_ff == last_corner);
      last_result = (head_kind == KIND_BAD)
                 || (sub_ff == LAST_SUB_FACE && corner_ff == last_corner);
      pop         = advance && last_result;

      sub_in    = sub_ff;
      corner_in = corner_ff;
      if (advance) begin
         if (last_result) begin
            sub_in    = '0;
            corner_in = '0;
         end else if (corner_ff == last_corner) begin
            sub_in    = sub_ff + 2'd1;
            corner_in = '0;
         end else begin
            corner_in = corner_ff + 2'd1;
         end
      end

      if (advance) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         o_ff          <= o_in;
         sub_out_ff    <= (head_kind == KIND_BAD) ? 2'd0 : sub_ff;
         corner_out_ff <= (head_kind == KIND_BAD) ? 2'd0 : corner_ff;
         cc_ff         <= cc;
         face_end_ff   <= face_end;
         run_end_ff    <= last_result;
         bad_ff        <= (head_kind == KIND_BAD);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff    <= '0;
         corner_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         sub_ff    <= sub_in;
         corner_ff <= corner_in;
         valid_ff  <= valid_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_ox           = o_ff[0];
   assign rsp_oy           = o_ff[1];
   assign rsp_oz           = o_ff[2];
   assign rsp_sub_face     = sub_out_ff;
   assign rsp_corner       = corner_out_ff;
   assign rsp_corner_count = cc_ff;
   assign rsp_face_end     = face_end_ff;
   assign rsp_run_end      = run_end_ff;
   assign rsp_bad_face     = bad_ff;

endmodule

// ===== src/polygon_midpoint_subdivide.sv =====
// Midpoint subdivision of a face into four sub-faces, one vertex in, one vertex out per cycle
// while neither side stalls. The first result of a face goes through the face queue and then
// the result register after its last vertex is accepted. Vertices are accepted while the face
// queue is not full; the single result register gives a quad face (4 vertices) 16 results.
// Reset: synchronous, clears the face collector, the face queue and the output valid.
// Depends on pms_pkg, pms_front, pms_queue and pms_back.
module polygon_midpoint_subdivide #(
   parameter int COORD_BITS = pms_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_vx,
   input  logic signed [COORD_BITS-1:0] req_vy,
   input  logic signed [COORD_BITS-1:0] req_vz,
   input  logic                         req_final_vertex,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_ox,
   output logic signed [COORD_BITS-1:0] rsp_oy,
   output logic signed [COORD_BITS-1:0] rsp_oz,
   output logic [1:0]                   rsp_sub_face,
   output logic [1:0]                   rsp_corner,
   output logic [2:0]                   rsp_corner_count,
   output logic                         rsp_face_end,
   output logic                         rsp_run_end,
   output logic                         rsp_bad_face
);
   import pms_pkg::*;

   queue_status_type             q_status;
   logic                         push, pop;
   logic signed [COORD_BITS-1:0] push_vert [MAX_VERTS][AXES];
   logic signed [COORD_BITS+1:0] push_sum [AXES];
   face_kind_type                push_kind;
   logic signed [COORD_BITS-1:0] head_vert [MAX_VERTS][AXES];
   logic signed [COORD_BITS+1:0] head_sum [AXES];
   face_kind_type                head_kind;

   pms_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_vx           (req_vx),
      .req_vy           (req_vy),
      .req_vz           (req_vz),
      .req_final_vertex (req_final_vertex),
      .q_status         (q_status),
      .push             (push),
      .push_vert        (push_vert),
      .push_sum         (push_sum),
      .push_kind        (push_kind)
   );

   pms_queue #(.COORD_BITS(COORD_BITS)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_vert (push_vert),
      .push_sum  (push_sum),
      .push_kind (push_kind),
      .pop       (pop),
      .head_vert (head_vert),
      .head_sum  (head_sum),
      .head_kind (head_kind),
      .q_status  (q_status)
   );

   pms_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_vert        (head_vert),
      .head_sum         (head_sum),
      .head_kind        (head_kind),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ox           (rsp_ox),
      .rsp_oy           (rsp_oy),
      .rsp_oz           (rsp_oz),
      .rsp_sub_face     (rsp_sub_face),
      .rsp_corner       (rsp_corner),
      .rsp_corner_count (rsp_corner_count),
      .rsp_face_end     (rsp_face_end),
      .rsp_run_end      (rsp_run_end),
      .rsp_bad_face     (rsp_bad_face)
   );

endmodule

// ===== tb/sv/tb_polygon_midpoint_subdivide.sv =====
// Self-checking testbench for polygon_midpoint_subdivide: faces of random and extreme vertices
// go in, and every sub-face vertex that comes out is checked against a predicted copy.
// Depends on pms_pkg and the polygon_midpoint_subdivide RTL.
module tb_polygon_midpoint_subdivide;
   timeunit 1ns;
   timeprecision 1ps;

   import pms_pkg::*;

   localparam int COORD_BITS  = COORD_BITS_DEF;
   localparam int VERTEX_GOAL = 450;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct {
      coord_type  x;
      coord_type  y;
      coord_type  z;
      logic [1:0] sub_face;
      logic [1:0] corner;
      logic [2:0] corner_count;
      logic       face_end;
      logic       run_end;
      logic       bad_face;
   } sub_vertex_type;

   class face_split_scoreboard;
      longint         corners_in[MAX_VERTS][AXES];
      int             held_count = 0;
      bit             too_many   = 0;
      sub_vertex_type pending_vertices[$];
      int             errors     = 0;

      function coord_type midpoint(int a, int b, int ax);
         longint s;
         s = corners_in[a][ax] + corners_in[b][ax];
         return COORD_BITS'(s >>> 1);
      endfunction

      function void add_vertex(coord_type pt[AXES], int sf, int cn, logic [2:0] cc,
                               bit fend, bit rend, bit bad);
         sub_vertex_type v;
         v.x = pt[0];
         v.y = pt[1];
         v.z = pt[2];
         v.sub_face = 2'(sf);
         v.corner = 2'(cn);
         v.corner_count = cc;
         v.face_end = fend;
         v.run_end = rend;
         v.bad_face = bad;
         pending_vertices = {pending_vertices, v};
      endfunction

      // Take one accepted request and queue the sub-face vertices it releases.
      function void note_vertex(coord_type vx, coord_type vy, coord_type vz, logic last);
         int        n;
         coord_type pt[AXES];
         longint    sum;
         if (held_count < MAX_VERTS) begin
            corners_in[held_count][0] = longint'(vx);
            corners_in[held_count][1] = longint'(vy);
            corners_in[held_count][2] = longint'(vz);
            held_count++;
         end else begin
            too_many = 1;
         end
         if (!last) return;
         n = too_many ? 0 : held_count;
         held_count = 0;
         too_many = 0;
         if (n == 4) begin
            for (int j = 0; j < 4; j++) begin
               for (int c = 0; c < 4; c++) begin
                  for (int ax = 0; ax < AXES; ax++) begin
                     case (c)
                        0: pt[ax] = COORD_BITS'(corners_in[j][ax]);
                        1: pt[ax] = midpoint(j, (j + 1) % 4, ax);
                        2: begin
                           sum = corners_in[0][ax] + corners_in[1][ax]
                               + corners_in[2][ax] + corners_in[3][ax];
                           pt[ax] = COORD_BITS'(sum >>> 2);
                        end
                        default: pt[ax] = midpoint((j + 3) % 4, j, ax);
                     endcase
                  end
                  add_vertex(pt, j, c, CC_QUAD, c == QUAD_LAST_CORNER,
                             j == LAST_SUB_FACE && c == QUAD_LAST_CORNER, 1'b0);
               end
            end
         end else if (n == 3) begin
            for (int j = 0; j < 4; j++) begin
               for (int c = 0; c < 3; c++) begin
                  for (int ax = 0; ax < AXES; ax++) begin
                     if (j == LAST_SUB_FACE) begin
                        // middle triangle: the midpoint of each edge
                        case (c)
                           0: pt[ax] = midpoint(0, 1, ax);
                           1: pt[ax] = midpoint(1, 2, ax);
                           default: pt[ax] = midpoint(0, 2, ax);
                        endcase
                     end else begin
                        case (c)
                           0: pt[ax] = COORD_BITS'(corners_in[j][ax]);
                           1: pt[ax] = midpoint(j, (j + 1) % 3, ax);
                           default: pt[ax] = midpoint((j + 2) % 3, j, ax);
                        endcase
                     end
                  end
                  add_vertex(pt, j, c, CC_TRI, c == TRI_LAST_CORNER,
                             j == LAST_SUB_FACE && c == TRI_LAST_CORNER, 1'b0);
               end
            end
         end else begin
            pt = '{default: '0};
            add_vertex(pt, 0, 0, CC_BAD, 1'b1, 1'b1, 1'b1);
         end
      endfunction

      function void check_vertex(sub_vertex_type got);
         sub_vertex_type want;
         if (pending_vertices.size() == 0) begin
            $error("unexpected result: x=%0d y=%0d z=%0d", got.x, got.y, got.z);
            errors++;
            return;
         end
         want = pending_vertices.pop_front();
         if (got.x !== want.x) begin
            $error("ox: expected %0d, got %0d", want.x, got.x);
            errors++;
         end
         if (got.y !== want.y) begin
            $error("oy: expected %0d, got %0d", want.y, got.y);
            errors++;
         end
         if (got.z !== want.z) begin
            $error("oz: expected %0d, got %0d", want.z, got.z);
            errors++;
         end
         if (got.sub_face !== want.sub_face) begin
            $error("sub_face: expected %0d, got %0d", want.sub_face, got.sub_face);
            errors++;
         end
         if (got.corner !== want.corner) begin
            $error("corner: expected %0d, got %0d", want.corner, got.corner);
            errors++;
         end
         if (got.corner_count !== want.corner_count) begin
            $error("corner_count: expected %0d, got %0d", want.corner_count,
                   got.corner_count);
            errors++;
         end
         if (got.face_end !== want.face_end) begin
            $error("face_end: expected %0d, got %0d", want.face_end, got.face_end);
            errors++;
         end
         if (got.run_end !== want.run_end) begin
            $error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
            errors++;
         end
         if (got.bad_face !== want.bad_face) begin
            $error("bad_face: expected %0d, got %0d", want.bad_face, got.bad_face);
            errors++;
         end
      endfunction
   endclass

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   coord_type  req_vx           = '0;
   coord_type  req_vy           = '0;
   coord_type  req_vz           = '0;
   logic       req_final_vertex = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   coord_type  rsp_ox;
   coord_type  rsp_oy;
   coord_type  rsp_oz;
   logic [1:0] rsp_sub_face;
   logic [1:0] rsp_corner;
   logic [2:0] rsp_corner_count;
   logic       rsp_face_end;
   logic       rsp_run_end;
   logic       rsp_bad_face;

   face_split_scoreboard sb = new;
   int  vertices_sent = 0;
   bit  req_burst     = 0;
   bit  rsp_burst     = 0;
   int  stall_left    = 0;

   polygon_midpoint_subdivide #(.COORD_BITS(COORD_BITS)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_vx           (req_vx),
      .req_vy           (req_vy),
      .req_vz           (req_vz),
      .req_final_vertex (req_final_vertex),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ox           (rsp_ox),
      .rsp_oy           (rsp_oy),
      .rsp_oz           (rsp_oz),
      .rsp_sub_face     (rsp_sub_face),
      .rsp_corner       (rsp_corner),
      .rsp_corner_count (rsp_corner_count),
      .rsp_face_end     (rsp_face_end),
      .rsp_run_end      (rsp_run_end),
      .rsp_bad_face     (rsp_bad_face)
   );

   always #2 clock = ~clock;

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0: return {1'b0, {(COORD_BITS-1){1'b1}}};
         1: return {1'b1, {(COORD_BITS-1){1'b0}}};
         2: return $urandom_range(0, 1) ? coord_type'(-1) : coord_type'(0);
         3, 4: return coord_type'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
         default: return coord_type'($urandom);
      endcase
   endfunction

   // Present one request and hold it until the block takes it.
   task automatic send_vertex(coord_type vx, coord_type vy, coord_type vz, logic last);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_vx           <= vx;
      req_vy           <= vy;
      req_vz           <= vz;
      req_final_vertex <= last;
      do @(posedge clock); while (req_stall);
      sb.note_vertex(vx, vy, vz, last);
      vertices_sent++;
   endtask

   task automatic send_face(int n);
      for (int i = 0; i < n; i++)
         send_vertex(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
   endtask

   // Result side: check each accepted result, then stall for a drawn number of cycles.
   always @(posedge clock) begin
      sub_vertex_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.x = rsp_ox;
         got.y = rsp_oy;
         got.z = rsp_oz;
         got.sub_face = rsp_sub_face;
         got.corner = rsp_corner;
         got.corner_count = rsp_corner_count;
         got.face_end = rsp_face_end;
         got.run_end = rsp_run_end;
         got.bad_face = rsp_bad_face;
         sb.check_vertex(got);
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
         stall_left = rsp_burst ? 0 : $urandom_range(0, 18);
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      coord_type max_c;
      coord_type min_c;
      int        n;
      max_c = {1'b0, {(COORD_BITS-1){1'b1}}};
      min_c = {1'b1, {(COORD_BITS-1){1'b0}}};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // quad at the positive extreme
      for (int i = 0; i < 4; i++) send_vertex(max_c, max_c, max_c, i == 3);
      // quad mixing extremes, zero and minus one
      send_vertex(max_c, min_c, coord_type'(-1), 0);
      send_vertex(min_c, coord_type'(-1), '0, 0);
      send_vertex(coord_type'(-1), '0, max_c, 0);
      send_vertex('0, max_c, min_c, 1);
      // triangle at the extremes
      send_vertex(min_c, min_c, max_c, 0);
      send_vertex(max_c, min_c, min_c, 0);
      send_vertex(coord_type'(1), min_c, max_c, 1);
      // odd negative sums round toward minus infinity
      send_vertex(coord_type'(-3), coord_type'(-1), coord_type'(5), 0);
      send_vertex('0, coord_type'(-2), coord_type'(-7), 0);
      send_vertex(coord_type'(2), coord_type'(0), coord_type'(-4), 1);
      // too few and too many vertices
      send_vertex(max_c, min_c, coord_type'(7), 1);
      send_vertex(coord_type'(3), coord_type'(4), coord_type'(5), 0);
      send_vertex(min_c, max_c, '0, 1);
      send_face(5);

      while (vertices_sent < VERTEX_GOAL) begin
         req_burst = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8: n = 4;
            9, 10, 11, 12, 13, 14, 15, 16: n = 3;
            17: n = $urandom_range(1, 2);
            default: n = $urandom_range(5, 7);
         endcase
         send_face(n);
      end
      req_valid <= 1'b0;

      while (sb.pending_vertices.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
      if (sb.errors == 0)
         $display("tb_polygon_midpoint_subdivide: PASS");
      else
         $display("tb_polygon_midpoint_subdivide: FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_polygon_midpoint_subdivide: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
src/pms_pkg.sv
src/pms_front.sv
src/pms_queue.sv
src/pms_back.sv
src/polygon_midpoint_subdivide.sv
tb/sv/tb_polygon_midpoint_subdivide.sv
